### sv/assert_macros.svh
// Assertion macros shared by the header parser RTL.
// Needs nothing else; taken in by `include in the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mhp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mhp assertion failed");

`endif

### sv/mhp_pkg.sv
// Types and constants for the MQTT fixed-header parser.
// No dependencies; used by mhp_parser, mhp_out_buf and the top level.
package mhp_pkg;

    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;
    localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

    typedef struct packed {
        logic [3:0]  msg_type;
        logic [1:0]  qos_level;
        logic        dup_flag;
        logic        retain_flag;
        logic [27:0] remaining_length;
        logic [15:0] topic_length;
        logic [2:0]  topic_offset;
        logic        has_msg_id;
        logic [15:0] msg_id;
        logic [16:0] payload_offset;
        logic [27:0] payload_length;
        logic        malformed;
    } t_result;

endpackage

### sv/mqtt_header_parser_core.sv
// MQTT fixed-header parser, top level.
// Depends on mhp_pkg, mhp_parser and mhp_out_buf.
//
// Input channel: one packet byte per transfer (i_data_byte) with
// i_start_of_packet high on the first byte of each packet; a start mark
// always restarts parsing and drops any unfinished packet.
// Output channel: at most one header result per packet, carrying type,
// flags, remaining length, topic length and offset, message id, payload
// offset and length, and a malformed flag.
// Throughput: one byte per cycle while o_ready is high. Each byte updates
// the parse registers through one short combinational step (one 28-bit
// add and one 28-bit compare/subtract at most).
// Result path: the result is registered in the output register, or in the
// skid register when the output register holds a result not taken yet.
// Stall: results sit in a two-entry buffer (output register plus skid
// register). o_ready falls only when both hold a result; it returns the
// cycle after the receiver takes one.
// Reset: synchronous, active low; the parser waits for a start mark and
// the result buffer is emptied. Bytes before the first start mark are
// ignored.
module mqtt_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_msg_type,
    output logic [1:0]  o_qos_level,
    output logic        o_dup_flag,
    output logic        o_retain_flag,
    output logic [27:0] o_remaining_length,
    output logic [15:0] o_topic_length,
    output logic [2:0]  o_topic_offset,
    output logic        o_has_msg_id,
    output logic [15:0] o_msg_id,
    output logic [16:0] o_payload_offset,
    output logic [27:0] o_payload_length,
    output logic        o_malformed
);

    logic             in_xfer;
    logic             res_valid;
    mhp_pkg::t_result res;
    mhp_pkg::t_result out_res;

    // A byte moves when the buffer has room for a possible result
    assign in_xfer = i_valid && o_ready;

    mhp_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (in_xfer),
        .i_data_byte       (i_data_byte),
        .i_start_of_packet (i_start_of_packet),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    mhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    assign o_msg_type         = out_res.msg_type;
    assign o_qos_level        = out_res.qos_level;
    assign o_dup_flag         = out_res.dup_flag;
    assign o_retain_flag      = out_res.retain_flag;
    assign o_remaining_length = out_res.remaining_length;
    assign o_topic_length     = out_res.topic_length;
    assign o_topic_offset     = out_res.topic_offset;
    assign o_has_msg_id       = out_res.has_msg_id;
    assign o_msg_id           = out_res.msg_id;
    assign o_payload_offset   = out_res.payload_offset;
    assign o_payload_length   = out_res.payload_length;
    assign o_malformed        = out_res.malformed;

endmodule

### sv/mhp_parser.sv
// Byte-wise parse state machine and header result logic.
// Depends on mhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mhp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_start_of_packet,
    output logic             o_res_valid,
    output mhp_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_WAIT, PH_LEN, PH_TLHI, PH_TLLO, PH_SKIP, PH_IDHI, PH_IDLO, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [27:0] r_len_acc, n_len_acc;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [15:0] r_topic_len, n_topic_len;
    logic [15:0] r_skip_cnt, n_skip_cnt;
    logic [15:0] r_msg_id, n_msg_id;

    logic        emit, bad_len;
    logic [27:0] grp;
    logic [3:0]  hdr_type;
    logic [1:0]  hdr_qos;
    logic        qos_nz;
    logic [16:0] var_hdr;

    assign hdr_type = r_first_byte[7:4];
    assign hdr_qos  = r_first_byte[2:1];
    assign qos_nz   = (hdr_qos != 2'd0);

    always_comb begin
        n_phase      = r_phase;
        n_first_byte = r_first_byte;
        n_len_acc    = r_len_acc;
        n_len_cnt    = r_len_cnt;
        n_topic_len  = r_topic_len;
        n_skip_cnt   = r_skip_cnt;
        n_msg_id     = r_msg_id;
        emit         = 1'b0;
        bad_len      = 1'b0;
        grp          = 28'd0;
        if (i_start_of_packet) begin
            n_first_byte = i_data_byte;
            n_len_acc    = 28'd0;
            n_len_cnt    = 3'd0;
            n_topic_len  = 16'd0;
            n_skip_cnt   = 16'd0;
            n_msg_id     = 16'd0;
            n_phase      = PH_LEN;
        end else begin
            case (r_phase)
                PH_LEN: begin
                    // 7-bit groups, least significant first
                    case (r_len_cnt[1:0])
                        2'd0:    grp = {21'd0, i_data_byte[6:0]};
                        2'd1:    grp = {14'd0, i_data_byte[6:0], 7'd0};
                        2'd2:    grp = {7'd0, i_data_byte[6:0], 14'd0};
                        default: grp = {i_data_byte[6:0], 21'd0};
                    endcase
                    n_len_acc = r_len_acc + grp;
                    n_len_cnt = {1'b0, r_len_cnt[1:0]} + 3'd1;
                    if (i_data_byte[7]) begin
                        if (n_len_cnt >= mhp_pkg::LEN_BYTES_MAX) begin
                            emit    = 1'b1;
                            bad_len = 1'b1;
                        end
                    end else if (hdr_type == mhp_pkg::TYPE_PUBLISH) begin
                        n_phase = PH_TLHI;
                    end else if (hdr_type inside {[mhp_pkg::TYPE_PUBACK:
                                                   mhp_pkg::TYPE_UNSUBACK]}) begin
                        n_phase = PH_IDHI;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_TLHI: begin
                    n_topic_len = {i_data_byte, 8'd0};
                    n_phase     = PH_TLLO;
                end
                PH_TLLO: begin
                    n_topic_len = {r_topic_len[15:8], i_data_byte};
                    n_skip_cnt  = n_topic_len;
                    if (n_skip_cnt != 16'd0) begin
                        n_phase = PH_SKIP;
                    end else if (qos_nz) begin
                        n_phase = PH_IDHI;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_skip_cnt = r_skip_cnt - 16'd1;
                    if (n_skip_cnt == 16'd0) begin
                        if (qos_nz) begin
                            n_phase = PH_IDHI;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
                PH_IDHI: begin
                    n_msg_id = {i_data_byte, 8'd0};
                    n_phase  = PH_IDLO;
                end
                PH_IDLO: begin
                    n_msg_id = {r_msg_id[15:8], i_data_byte};
                    emit     = 1'b1;
                end
                default: begin
                end
            endcase
            if (emit) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Result fields, taken from the state as it stands after this byte
    assign var_hdr = 17'd2 + {1'b0, n_topic_len} + (qos_nz ? 17'd2 : 17'd0);

    always_comb begin
        o_res                  = '0;
        o_res.msg_type         = hdr_type;
        o_res.qos_level        = hdr_qos;
        o_res.dup_flag         = r_first_byte[3];
        o_res.retain_flag      = r_first_byte[0];
        o_res.remaining_length = n_len_acc;
        o_res.malformed        = bad_len;
        if (!bad_len) begin
            if (hdr_type == mhp_pkg::TYPE_PUBLISH) begin
                o_res.topic_length   = n_topic_len;
                o_res.topic_offset   = n_len_cnt + 3'd3;
                o_res.payload_offset = var_hdr + {14'd0, n_len_cnt} + 17'd1;
                o_res.has_msg_id     = qos_nz;
                o_res.msg_id         = qos_nz ? n_msg_id : 16'd0;
                if (n_len_acc >= {11'd0, var_hdr}) begin
                    o_res.payload_length = n_len_acc - {11'd0, var_hdr};
                end else begin
                    o_res.malformed = 1'b1;
                end
            end else if (hdr_type inside {[mhp_pkg::TYPE_PUBACK:
                                           mhp_pkg::TYPE_UNSUBACK]}) begin
                o_res.has_msg_id = 1'b1;
                o_res.msg_id     = n_msg_id;
            end
        end
    end

    assign o_res_valid = i_step && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_first_byte <= 8'd0;
            r_len_acc    <= 28'd0;
            r_len_cnt    <= 3'd0;
            r_topic_len  <= 16'd0;
            r_skip_cnt   <= 16'd0;
            r_msg_id     <= 16'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_first_byte <= n_first_byte;
            r_len_acc    <= n_len_acc;
            r_len_cnt    <= n_len_cnt;
            r_topic_len  <= n_topic_len;
            r_skip_cnt   <= n_skip_cnt;
            r_msg_id     <= n_msg_id;
        end
    end

    `MHP_ASSERT_NXT(a_emit_done, i_clk, i_rst_n, o_res_valid, r_phase == PH_DONE)
    `MHP_ASSERT_IMP(a_pub_id, i_clk, i_rst_n,
        o_res_valid && !o_res.malformed && o_res.msg_type == mhp_pkg::TYPE_PUBLISH,
        o_res.has_msg_id == (o_res.qos_level != 2'd0))
    `MHP_ASSERT_IMP(a_nonpub_zero, i_clk, i_rst_n,
        o_res_valid && o_res.msg_type != mhp_pkg::TYPE_PUBLISH,
        o_res.payload_length == 28'd0 && o_res.payload_offset == 17'd0)

endmodule

### sv/mhp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on mhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mhp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mhp_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output mhp_pkg::t_result o_data
);

    logic             r_main_valid, r_skid_valid;
    mhp_pkg::t_result r_main_data, r_skid_data;
    logic             pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main_data  <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_data  <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid_data  <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    `MHP_ASSERT_IMP(a_skid_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `MHP_ASSERT_IMP(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_valid),
        $past(r_main_valid && !i_ready))
    `MHP_ASSERT_NXT(a_drain, i_clk, i_rst_n, pop && !r_skid_valid && !i_push,
        !r_main_valid)

endmodule
